// ===== design/mrrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrrc_pkg
// Shared types, codes and helper functions for the response frame checker.
// ----------------------------------------------------------------------------
package mrrc_pkg;

    // width used for frame length arithmetic (5 + 2 * 65535 needs 18 bits)
    localparam int LEN_W = 18;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_SLAVE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_FUNCTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_QUANTITY = 2'd2;

    // function codes with their own response length rule
    localparam logic [7:0] FC_READ_COILS    = 8'd1;
    localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
    localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS    = 8'd16;

    localparam logic [LEN_W-1:0] MIN_FRAME_LEN   = 18'd5;
    localparam logic [LEN_W-1:0] WRITE_FRAME_LEN = 18'd8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_CRC   = 3'd1,
        ST_SLAVE = 3'd2,
        ST_FUNC  = 3'd3,
        ST_COUNT = 3'd4,
        ST_LEN   = 3'd5,
        ST_SHORT = 3'd6
    } status_t;

    // frame state after the current word has been folded in
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             overflow;
        logic [7:0]       slave;
        logic [7:0]       func;
        logic [7:0]       count;
        logic [15:0]      crc;
    } frame_t;

    // pending request
    typedef struct packed {
        logic [7:0]  slave;
        logic [7:0]  func;
        logic [15:0] quantity;
    } cfg_t;

    // reflected crc-16, one byte, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [LEN_W-1:0] expected_length(input logic [7:0] code,
                                                         input logic [15:0] qty);
        logic [LEN_W-1:0] q;
        logic [LEN_W-1:0] len;
        q = LEN_W'(qty);
        case (code)
            FC_READ_COILS: begin
                len = MIN_FRAME_LEN + ((q + 18'd7) >> 3);
            end
            FC_READ_HOLDING: begin
                len = MIN_FRAME_LEN + (q << 1);
            end
            FC_WRITE_COILS, FC_WRITE_REGS: begin
                len = WRITE_FRAME_LEN;
            end
            default: begin
                len = MIN_FRAME_LEN;
            end
        endcase
        return len;
    endfunction

endpackage

// ===== design/mrrc_frame_eval.sv =====
// ----------------------------------------------------------------------------
// mrrc_frame_eval
// Ordered checks of a complete response frame against the pending request.
// ----------------------------------------------------------------------------
module mrrc_frame_eval (
    input  mrrc_pkg::frame_t  frame,
    input  mrrc_pkg::cfg_t    cfg,
    output mrrc_pkg::status_t status,
    output logic              is_exception
);

    logic                       too_short;
    logic                       exc_match;
    logic                       func_ok;
    logic                       count_bad;
    logic [mrrc_pkg::LEN_W-1:0] exp_len;

    // code + 128 without wrap: only possible for request codes below 128
    assign exc_match = frame.func[7] && !cfg.func[7] && (frame.func[6:0] == cfg.func[6:0]);
    assign func_ok   = (frame.func == cfg.func) || exc_match;
    assign too_short = (frame.len < mrrc_pkg::MIN_FRAME_LEN) && !frame.overflow;
    assign exp_len   = mrrc_pkg::expected_length(frame.func, cfg.quantity);

    always_comb begin
        count_bad = 1'b0;
        if (frame.func inside {mrrc_pkg::FC_READ_COILS, mrrc_pkg::FC_READ_HOLDING}) begin
            count_bad = mrrc_pkg::LEN_W'(frame.count) != (frame.len - mrrc_pkg::MIN_FRAME_LEN);
        end
    end

    always_comb begin
        if (too_short) begin
            status = mrrc_pkg::ST_SHORT;
        end else if (frame.crc != 16'h0000) begin
            status = mrrc_pkg::ST_CRC;
        end else if (frame.slave != cfg.slave) begin
            status = mrrc_pkg::ST_SLAVE;
        end else if (!func_ok) begin
            status = mrrc_pkg::ST_FUNC;
        end else if (frame.overflow) begin
            status = mrrc_pkg::ST_LEN;
        end else if (count_bad) begin
            status = mrrc_pkg::ST_COUNT;
        end else if (frame.len != exp_len) begin
            status = mrrc_pkg::ST_LEN;
        end else begin
            status = mrrc_pkg::ST_OK;
        end
    end

    assign is_exception = !too_short && exc_match;

endmodule

// ===== design/modbus_rtu_response_checker_unit.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_unit
// Checks a response frame, one byte per word, against the pending request.
// A frame's last word lands in the input register; once the result register
// is free, its status word is registered there and waits until it is taken.
// Throughput: one byte word per cycle; words that are not a frame's last keep
// entering while a status waits, a last word holds in the input register and
// stalls the input until the result register is free.
// Reset (aresetn, synchronous, active low): frame state cleared, crc to
// all ones, request registers zero, no status pending.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_unit #(
    parameter int MAX_FRAME = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // request configuration
    input  logic                                cfg_wr_en,
    input  logic [mrrc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mrrc_pkg::CFG_DATA_W-1:0]     cfg_wr_data,

    // received bytes
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_rx_byte,
    input  logic                                s_frame_end,

    // frame status
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_status,
    output logic                                m_frame_ok,
    output logic                                m_is_exception
);

    // byte position counter holds 0 .. MAX_FRAME
    localparam int PW = $clog2(MAX_FRAME + 1);

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // running frame state
    logic [15:0]   crc_reg;
    logic [PW-1:0] pos_reg;
    logic          ovf_reg;
    logic [7:0]    slave_reg;
    logic [7:0]    func_reg;
    logic [7:0]    count_reg;

    // request registers
    logic [7:0]  cfg_slave_reg;
    logic [7:0]  cfg_func_reg;
    logic [15:0] cfg_qty_reg;

    // result register
    logic              m_valid_reg;
    mrrc_pkg::status_t m_status_reg;
    logic              m_ok_reg;
    logic              m_exc_reg;

    // next frame state
    logic [15:0]   crc_next;
    logic [PW-1:0] pos_next;
    logic          ovf_next;
    logic [7:0]    slave_next;
    logic [7:0]    func_next;
    logic [7:0]    count_next;

    logic              out_free;
    logic              advance;
    logic              finish;
    mrrc_pkg::frame_t  frame;
    mrrc_pkg::cfg_t    cfg;
    mrrc_pkg::status_t eval_status;
    logic              eval_exc;

    // the last word of a frame moves only when the result register can take it
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign finish   = advance && in_last_reg;
    assign s_ready  = !in_valid_reg || advance;

    // fold the byte in the input register into the frame state
    always_comb begin
        crc_next   = mrrc_pkg::crc_byte(crc_reg, in_byte_reg);
        slave_next = slave_reg;
        func_next  = func_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        ovf_next   = ovf_reg;
        // header bytes: address, function code, byte count
        if (pos_reg == PW'(0)) begin
            slave_next = in_byte_reg;
        end else if (pos_reg == PW'(1)) begin
            func_next = in_byte_reg;
        end else if (pos_reg == PW'(2)) begin
            count_next = in_byte_reg;
        end
        // counter saturates, anything past it marks the frame overlong
        if (pos_reg >= PW'(MAX_FRAME)) begin
            ovf_next = 1'b1;
        end else begin
            pos_next = pos_reg + PW'(1);
        end
    end

    assign frame.len      = mrrc_pkg::LEN_W'(pos_next);
    assign frame.overflow = ovf_next;
    assign frame.slave    = slave_next;
    assign frame.func     = func_next;
    assign frame.count    = count_next;
    assign frame.crc      = crc_next;

    assign cfg.slave    = cfg_slave_reg;
    assign cfg.func     = cfg_func_reg;
    assign cfg.quantity = cfg_qty_reg;

    mrrc_frame_eval u_eval (
        .frame        (frame),
        .cfg          (cfg),
        .status       (eval_status),
        .is_exception (eval_exc)
    );

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
            in_last_reg <= s_frame_end;
        end
    end

    // input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // frame state, cleared after the last word of each frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= mrrc_pkg::CRC_INIT;
            pos_reg   <= '0;
            ovf_reg   <= 1'b0;
            slave_reg <= '0;
            func_reg  <= '0;
            count_reg <= '0;
        end else if (finish) begin
            crc_reg   <= mrrc_pkg::CRC_INIT;
            pos_reg   <= '0;
            ovf_reg   <= 1'b0;
            slave_reg <= '0;
            func_reg  <= '0;
            count_reg <= '0;
        end else if (advance) begin
            crc_reg   <= crc_next;
            pos_reg   <= pos_next;
            ovf_reg   <= ovf_next;
            slave_reg <= slave_next;
            func_reg  <= func_next;
            count_reg <= count_next;
        end
    end

    // request registers, writes to unused indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_slave_reg <= '0;
            cfg_func_reg  <= '0;
            cfg_qty_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mrrc_pkg::REG_EXPECTED_SLAVE: begin
                    cfg_slave_reg <= cfg_wr_data[7:0];
                end
                mrrc_pkg::REG_REQUEST_FUNCTION: begin
                    cfg_func_reg <= cfg_wr_data[7:0];
                end
                mrrc_pkg::REG_REQUEST_QUANTITY: begin
                    cfg_qty_reg <= cfg_wr_data[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (finish) begin
            m_status_reg <= eval_status;
            m_ok_reg     <= (eval_status == mrrc_pkg::ST_OK);
            m_exc_reg    <= eval_exc;
        end
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_frame_ok     = m_ok_reg;
    assign m_is_exception = m_exc_reg;

`ifndef ASSERT_OFF
    // counter never runs past its saturation point
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= PW'(MAX_FRAME))
        else $error("byte position beyond frame limit");

    // overlong flag only once the counter has saturated
    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> pos_reg == PW'(MAX_FRAME))
        else $error("overflow flagged before counter saturated");

    // a finished frame leaves clean state for the next one
    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> (pos_reg == '0) && (crc_reg == mrrc_pkg::CRC_INIT) && !ovf_reg)
        else $error("frame state not cleared after last word");

    // frame_ok agrees with the status code
    a_ok_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_ok_reg == (m_status_reg == mrrc_pkg::ST_OK))
        else $error("frame_ok disagrees with status");

    // exception never reported on a too short frame
    a_exc_short: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_exc_reg) |-> m_status_reg != mrrc_pkg::ST_SHORT)
        else $error("exception reported on too short frame");
`endif

endmodule
